// File: rtl/core/blpt_pkg.sv
// Shared types, constants and the byte-to-symbol map of the byte-level pretokenizer.
package blpt_pkg;

  localparam int unsigned OUT_DEPTH = 4;

  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_UP_Z    = 8'h5A;
  localparam logic [7:0] CH_LO_A    = 8'h61;
  localparam logic [7:0] CH_LO_Z    = 8'h7A;
  localparam logic [7:0] CASE_BIT   = 8'h20;

  localparam logic [7:0] LOW_LAST   = 8'd32;
  localparam logic [7:0] MID_FIRST  = 8'd127;
  localparam logic [7:0] MID_LAST   = 8'd160;
  localparam logic [7:0] SOFT_HYPH  = 8'd173;
  localparam logic [8:0] LOW_BASE   = 9'd256;
  localparam logic [8:0] MID_OFFSET = 9'd162;
  localparam logic [8:0] HYPH_SYM   = 9'd323;

  typedef struct packed {
    logic [8:0] symbol;
    logic       word_end;
    logic       text_end;
    logic       run_last;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } slot_t;

  typedef struct packed {
    logic       valid;
    logic [8:0] symbol;
    logic       is_alnum;
  } held_t;

  typedef struct packed {
    logic room_two;
    logic empty;
    logic full;
  } fifo_stat_t;

  function automatic logic [8:0] map_symbol(input logic [7:0] b);
    logic [8:0] sym;
    sym = {1'b0, b};
    if (b <= LOW_LAST) begin
      sym = LOW_BASE + {1'b0, b};
    end else if (b >= MID_FIRST && b <= MID_LAST) begin
      sym = {1'b0, b} + MID_OFFSET;
    end else if (b == SOFT_HYPH) begin
      sym = HYPH_SYM;
    end
    return sym;
  endfunction

endpackage

// File: rtl/core/blpt_classify.sv
// Byte classification, symbol mapping and result forming for one registered item.
module blpt_classify
  import blpt_pkg::*;
(
  input  logic [7:0] byte_i,
  input  logic       eot_i,
  input  held_t      held_i,
  output slot_t      first_o,
  output slot_t      second_o,
  output held_t      held_o
);

  logic [7:0] low_byte;
  logic       is_ws;
  logic       is_alnum;
  logic [8:0] sym;

  always_comb begin
    low_byte = byte_i;
    if (byte_i >= CH_UP_A && byte_i <= CH_UP_Z) begin
      low_byte = byte_i | CASE_BIT;
    end
  end

  assign is_ws    = (low_byte == CH_SPACE) || (low_byte == CH_TAB) ||
                    (low_byte == CH_LF) || (low_byte == CH_CR);
  assign is_alnum = (low_byte >= CH_LO_A && low_byte <= CH_LO_Z) ||
                    (low_byte >= CH_ZERO && low_byte <= CH_NINE);
  assign sym      = map_symbol(low_byte);

  always_comb begin
    first_o  = '0;
    second_o = '0;
    held_o   = held_i;
    if (is_ws) begin
      first_o.valid        = held_i.valid;
      first_o.res.symbol   = held_i.symbol;
      first_o.res.word_end = 1'b1;
      first_o.res.text_end = eot_i;
      first_o.res.run_last = 1'b1;
      held_o.valid         = 1'b0;
    end else begin
      first_o.valid        = held_i.valid;
      first_o.res.symbol   = held_i.symbol;
      first_o.res.word_end = held_i.is_alnum != is_alnum;
      first_o.res.text_end = 1'b0;
      first_o.res.run_last = !eot_i;
      second_o.valid        = eot_i;
      second_o.res.symbol   = sym;
      second_o.res.word_end = 1'b1;
      second_o.res.text_end = 1'b1;
      second_o.res.run_last = 1'b1;
      held_o.valid    = !eot_i;
      held_o.symbol   = sym;
      held_o.is_alnum = is_alnum;
    end
  end

endmodule

// File: rtl/core/blpt_result_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per cycle while pop_i is set.
module blpt_result_fifo
  import blpt_pkg::*;
#(
  parameter int unsigned Depth = OUT_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  slot_t      first_i,
  input  slot_t      second_i,
  input  logic       pop_i,
  output result_t    head_o,
  output fifo_stat_t stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  result_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, wr_ptr1, wr_ptr2;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic [1:0]      push_n;
  result_t         w0;

  assign push_n  = {1'b0, first_i.valid} + {1'b0, second_i.valid};
  assign w0      = first_i.valid ? first_i.res : second_i.res;
  assign wr_ptr1 = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
  assign wr_ptr2 = (wr_ptr1 == PtrW'(Depth - 1)) ? '0 : wr_ptr1 + 1'b1;

  always_comb begin
    unique case (push_n)
      2'd1:    wr_ptr_d = wr_ptr1;
      2'd2:    wr_ptr_d = wr_ptr2;
      default: wr_ptr_d = wr_ptr_q;
    endcase
  end

  assign rd_ptr_d = !pop_i ? rd_ptr_q :
                    (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
  assign count_d  = count_q + CntW'(push_n) - CntW'(pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      mem_q[wr_ptr_q] <= w0;
    end
    if (push_n == 2'd2) begin
      mem_q[wr_ptr1] <= second_i.res;
    end
  end

  assign head_o          = mem_q[rd_ptr_q];
  assign stat_o.room_two = count_q <= CntW'(Depth - 2);
  assign stat_o.empty    = count_q == '0;
  assign stat_o.full     = count_q == CntW'(Depth);

endmodule

// File: rtl/core/byte_level_pretokenizer_unit.sv
// Top level of the byte-level pretokenizer: input register, held byte, result queue.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+------------------------------------------
//   input    | in_valid_i / in_stall_o    | in_byte_i, end_of_text_i
//   output   | out_valid_o / out_stall_i  | symbol_o, word_end_o, text_end_o, run_last_o
//
// One byte per cycle is taken while in_stall_o is low; a byte's results are written
// into the queue when it leaves the input register and leave from the queue head.
// The queue drains one result per cycle while out_stall_i is low, so a byte that
// yields two results hands them out one after the other. The input register holds
// while the queue has room for fewer than two results. Reset empties the queue and drops the held byte.
module byte_level_pretokenizer_unit
  import blpt_pkg::*;
#(
  parameter int unsigned OutDepth = OUT_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [8:0] symbol_o,
  output logic       word_end_o,
  output logic       text_end_o,
  output logic       run_last_o
);

  logic       stg_valid_q, stg_valid_d;
  logic [7:0] byte_q;
  logic       eot_q;
  held_t      held_q, held_d;
  held_t      held_d_raw;
  slot_t      first, second, push_a, push_b;
  result_t    head;
  fifo_stat_t stat;
  logic       fire, accept, pop;

  assign fire        = stg_valid_q && stat.room_two;
  assign in_stall_o  = stg_valid_q && !fire;
  assign accept      = in_valid_i && !in_stall_o;
  assign stg_valid_d = accept ? 1'b1 : (fire ? 1'b0 : stg_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
      held_q      <= '0;
    end else begin
      stg_valid_q <= stg_valid_d;
      held_q      <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= in_byte_i;
      eot_q  <= end_of_text_i;
    end
  end

  blpt_classify u_classify (
    .byte_i   (byte_q),
    .eot_i    (eot_q),
    .held_i   (held_q),
    .first_o  (first),
    .second_o (second),
    .held_o   (held_d_raw)
  );

  assign held_d = fire ? held_d_raw : held_q;

  always_comb begin
    push_a       = first;
    push_b       = second;
    push_a.valid = fire && first.valid;
    push_b.valid = fire && second.valid;
  end

  blpt_result_fifo #(
    .Depth (OutDepth)
  ) u_result_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .first_i  (push_a),
    .second_i (push_b),
    .pop_i    (pop),
    .head_o   (head),
    .stat_o   (stat)
  );

  assign out_valid_o = !stat.empty;
  assign pop         = out_valid_o && !out_stall_i;
  assign symbol_o    = head.symbol;
  assign word_end_o  = head.word_end;
  assign text_end_o  = head.text_end;
  assign run_last_o  = head.run_last;

`ifndef SYNTHESIS
  a_text_end_ends_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!text_end_o || word_end_o))
    else $error("text_end without word_end");

  a_eot_clears_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && eot_q) |=> !held_q.valid)
    else $error("held byte survives end of text");

  a_run_last_on_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && first.valid && second.valid) |->
      (!first.res.run_last && second.res.run_last))
    else $error("run_last misplaced on a two-result item");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.full |-> !fire)
    else $error("push into a full result queue");
`endif

endmodule
